// ===== rtl/voxel_flow_density_scatter_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef VOXEL_FLOW_DENSITY_SCATTER_MACROS_SVH
`define VOXEL_FLOW_DENSITY_SCATTER_MACROS_SVH
`ifndef SYNTH
// The condition must never hold while out of reset.
`define VFDS_ASSERT_NEVER(lbl, ck, rstn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
// When the first expression holds, the second must hold in the same cycle.
`define VFDS_ASSERT_IMPLIES(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
`else
`define VFDS_ASSERT_NEVER(lbl, ck, rstn, cond)
`define VFDS_ASSERT_IMPLIES(lbl, ck, rstn, ante, cons)
`endif
`endif

// ===== rtl/vfds_pkg.sv =====
package vfds_pkg;

	// Opcodes of an input item.
	localparam logic OP_DEPOSIT = 1'b0;
	localparam logic OP_READ    = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	// One in unsigned Q1.16.
	localparam logic [16:0] ONE16 = 17'h10000;

	// Saturation limits of the signed 40-bit accumulator, at sum width.
	localparam logic signed [42:0] ACC_MAX = 43'sh07F_FFFF_FFFF;
	localparam logic signed [42:0] ACC_MIN = -43'sh080_0000_0000;

	typedef struct packed {
		logic               opcode;
		logic [4:0]         voxel_x;
		logic [4:0]         voxel_y;
		logic [4:0]         voxel_z;
		logic signed [15:0] flow_x;
		logic signed [15:0] flow_y;
		logic signed [15:0] flow_z;
		logic [31:0]        old_density;
	} in_item_t;

	typedef struct packed {
		logic signed [39:0] voxel_density;
		logic               saturated;
	} out_item_t;

	// Flow magnitude and unit direction from the normalize unit.
	typedef struct packed {
		logic [17:0] mag_f;
		logic [16:0] a_x;
		logic [16:0] a_y;
		logic [16:0] a_z;
	} norm_res_t;

endpackage

// ===== rtl/voxel_flow_density_scatter.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_data (in_item_t)
// out      output     out_valid/out_ready  out_data (out_item_t)
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Items and register writes are taken only in the idle state, one item in flight at a time.
// A read reads the voxel, writes it back as zero, then waits in the output state while
// the output register is still full. A zero-flow deposit reads and writes the source voxel;
// a deposit outside the extent does nothing. A nonzero-flow deposit runs the normalize unit,
// then for each corner the multiply chain and, inside the grid only, a read and a write, then the source voxel.
// After reset a clearing pass writes every entry; nothing is taken.
`include "voxel_flow_density_scatter_macros.svh"
module voxel_flow_density_scatter import vfds_pkg::*; #(
	parameter int AXIS_SIZE = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);

	localparam int CELLS = AXIS_SIZE * AXIS_SIZE * AXIS_SIZE;
	localparam int CAW = $clog2(CELLS);
	localparam logic [8:0] EXT_MAX = 9'(AXIS_SIZE);
	localparam logic [CAW-1:0] CLR_LAST = CAW'(CELLS - 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_NORM   = 4'd1;
	localparam logic [3:0] S_MUL1   = 4'd2;
	localparam logic [3:0] S_MUL2   = 4'd3;
	localparam logic [3:0] S_MUL3   = 4'd4;
	localparam logic [3:0] S_MUL4   = 4'd5;
	localparam logic [3:0] S_C_RD   = 4'd6;
	localparam logic [3:0] S_C_WR   = 4'd7;
	localparam logic [3:0] S_SRC_RD = 4'd8;
	localparam logic [3:0] S_SRC_WR = 4'd9;
	localparam logic [3:0] S_RD_RD  = 4'd10;
	localparam logic [3:0] S_RD_WR  = 4'd11;
	localparam logic [3:0] S_RD_OUT = 4'd12;

	logic [3:0]          state_q;
	logic                clr_busy_q;
	logic [CAW-1:0]      clr_cnt_q;
	logic [5:0]          size_x_q, size_y_q, size_z_q;
	logic [8:0]          ext_x, ext_y, ext_z;
	logic [4:0]          pos_x_q, pos_y_q, pos_z_q;
	logic signed [15:0]  flow_x_q, flow_y_q, flow_z_q;
	logic [31:0]         d_q;
	logic [2:0]          corner_q;
	logic [CAW-1:0]      addr_q;
	logic                hit_q;
	logic [33:0]         mul1_q;
	logic [33:0]         mul2_q;
	logic [34:0]         mul3_q;
	logic [50:0]         mul4_q;
	logic [37:0]         moved_sum_q;
	out_item_t           res_q;
	out_item_t           out_q;
	logic                out_valid_q;
	logic                accept;
	logic                in_inside;
	logic                zero_flow;
	logic [15:0]         abs_x, abs_y, abs_z;
	logic                norm_start;
	logic                norm_done;
	norm_res_t           norm_res;
	logic [16:0]         sel_x, sel_y, sel_z;
	logic [2:0]          step;
	logic signed [9:0]   rx, ry, rz;
	logic [9:0]          ux, uy, uz;
	logic                cur_hit;
	logic [CAW-1:0]      cur_addr;
	logic                mem_we, mem_re;
	logic [CAW-1:0]      mem_waddr, mem_raddr;
	logic [40:0]         mem_wdata, mem_rdata;
	logic signed [41:0]  delta;
	logic signed [42:0]  sum;
	logic [40:0]         upd;
	logic                emit;

	function automatic logic [8:0] extent(input logic [5:0] s);
		logic [8:0] w;
		w = {3'b000, s};
		return (w > EXT_MAX) ? EXT_MAX : w;
	endfunction

	// Coordinate after an optional step against the sign of the flow.
	function automatic logic signed [9:0] step_coord(input logic [4:0] p,
			input logic signed [15:0] fl, input logic st);
		logic signed [9:0] r;
		r = signed'({5'b00000, p});
		if (st) begin
			if (fl > 16'sd0) r = r - 10'sd1;
			else r = r + 10'sd1;
		end
		return r;
	endfunction

	function automatic logic in_range(input logic signed [9:0] r, input logic [8:0] e);
		return (r >= 10'sd0) && (r < signed'({1'b0, e}));
	endfunction

	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		return (v < 16'sd0) ? 16'(-v) : 16'(v);
	endfunction

	assign ext_x = extent(size_x_q);
	assign ext_y = extent(size_y_q);
	assign ext_z = extent(size_z_q);

	assign in_ready  = (state_q == S_IDLE) && !clr_busy_q;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = (state_q == S_IDLE) && !clr_busy_q;
	assign in_inside = ({4'b0000, in_data.voxel_x} < ext_x) &&
		({4'b0000, in_data.voxel_y} < ext_y) && ({4'b0000, in_data.voxel_z} < ext_z);
	assign zero_flow = (in_data.flow_x == 16'sd0) && (in_data.flow_y == 16'sd0) &&
		(in_data.flow_z == 16'sd0);
	assign abs_x = mag16(in_data.flow_x);
	assign abs_y = mag16(in_data.flow_y);
	assign abs_z = mag16(in_data.flow_z);
	assign norm_start = accept && (in_data.opcode == OP_DEPOSIT) && in_inside && !zero_flow;

	vfds_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.mag_x  (abs_x),
		.mag_y  (abs_y),
		.mag_z  (abs_z),
		.done   (norm_done),
		.res    (norm_res)
	);

	// Corner weight factors: |u| on a stepped axis, 1-|u| otherwise.
	assign sel_x = corner_q[0] ? norm_res.a_x : 17'(ONE16 - norm_res.a_x);
	assign sel_y = corner_q[1] ? norm_res.a_y : 17'(ONE16 - norm_res.a_y);
	assign sel_z = corner_q[2] ? norm_res.a_z : 17'(ONE16 - norm_res.a_z);

	// Current voxel: the corner in the first multiply state, else the source.
	assign step = (state_q == S_MUL1) ? corner_q : 3'b000;
	assign rx = step_coord(pos_x_q, flow_x_q, step[0]);
	assign ry = step_coord(pos_y_q, flow_y_q, step[1]);
	assign rz = step_coord(pos_z_q, flow_z_q, step[2]);
	assign ux = rx;
	assign uy = ry;
	assign uz = rz;
	assign cur_hit = in_range(rx, ext_x) && in_range(ry, ext_y) && in_range(rz, ext_z);
	assign cur_addr = CAW'(CAW'(uz) * CAW'(AXIS_SIZE * AXIS_SIZE) +
		CAW'(uy) * CAW'(AXIS_SIZE) + CAW'(ux));

	// Saturating accumulate of the entry just read.
	assign delta = (state_q == S_C_WR) ? signed'({7'b0, mul4_q[50:16]}) :
		signed'({10'b0, d_q}) - signed'({4'b0, moved_sum_q});
	assign sum = 43'(signed'(mem_rdata[39:0])) + 43'(delta);
	always_comb begin
		if (sum > ACC_MAX) begin
			upd = {1'b1, ACC_MAX[39:0]};
		end else if (sum < ACC_MIN) begin
			upd = {1'b1, ACC_MIN[39:0]};
		end else begin
			upd = {mem_rdata[40], sum[39:0]};
		end
	end

	// Memory port selection.
	always_comb begin
		mem_re    = (state_q == S_C_RD && hit_q) || state_q == S_SRC_RD || state_q == S_RD_RD;
		mem_raddr = (state_q == S_C_RD) ? addr_q : cur_addr;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = upd;
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (state_q == S_C_WR || state_q == S_SRC_WR) begin
			mem_we = 1'b1;
		end else if (state_q == S_RD_WR) begin
			mem_we    = 1'b1;
			mem_wdata = '0;
		end
	end

	vfds_grid_ram #(
		.DEPTH (CELLS),
		.AW    (CAW)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign emit = (state_q == S_RD_OUT) && (!out_valid_q || out_ready);

	// Control: sequencer, clearing pass, registers, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_busy_q  <= 1'b1;
			clr_cnt_q   <= '0;
			size_x_q    <= 6'd32;
			size_y_q    <= 6'd32;
			size_z_q    <= 6'd32;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CLR_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SIZE_X: size_x_q <= cfg_data;
					REG_SIZE_Y: size_y_q <= cfg_data;
					REG_SIZE_Z: size_z_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					corner_q <= '0;
					if (accept) begin
						if (in_data.opcode == OP_READ) begin
							state_q <= in_inside ? S_RD_RD : S_RD_OUT;
						end else if (!in_inside) begin
							state_q <= S_IDLE;
						end else if (zero_flow) begin
							state_q <= S_SRC_RD;
						end else begin
							state_q <= S_NORM;
						end
					end
				end
				S_NORM:   if (norm_done) state_q <= S_MUL1;
				S_MUL1:   state_q <= S_MUL2;
				S_MUL2:   state_q <= S_MUL3;
				S_MUL3:   state_q <= S_MUL4;
				S_MUL4:   state_q <= S_C_RD;
				S_C_RD: begin
					if (hit_q) begin
						state_q <= S_C_WR;
					end else begin
						corner_q <= corner_q + 3'd1;
						state_q  <= (corner_q == 3'd7) ? S_SRC_RD : S_MUL1;
					end
				end
				S_C_WR: begin
					corner_q <= corner_q + 3'd1;
					state_q  <= (corner_q == 3'd7) ? S_SRC_RD : S_MUL1;
				end
				S_SRC_RD: state_q <= S_SRC_WR;
				S_SRC_WR: state_q <= S_IDLE;
				S_RD_RD:  state_q <= S_RD_WR;
				S_RD_WR:  state_q <= S_RD_OUT;
				S_RD_OUT: if (emit) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Item fields, multiply chain and result holding registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_x_q     <= in_data.voxel_x;
			pos_y_q     <= in_data.voxel_y;
			pos_z_q     <= in_data.voxel_z;
			flow_x_q    <= in_data.flow_x;
			flow_y_q    <= in_data.flow_y;
			flow_z_q    <= in_data.flow_z;
			d_q         <= in_data.old_density;
			moved_sum_q <= '0;
			res_q       <= '0;
		end
		if (state_q == S_MUL1 || state_q == S_SRC_RD || state_q == S_RD_RD) begin
			addr_q <= cur_addr;
			hit_q  <= cur_hit;
		end
		mul1_q <= 34'(sel_x) * 34'(sel_y);
		mul2_q <= 34'(mul1_q[32:16]) * 34'(sel_z);
		mul3_q <= 35'(mul2_q[32:16]) * 35'(norm_res.mag_f);
		mul4_q <= 51'(mul3_q[34:16]) * 51'(d_q);
		if (state_q == S_C_RD && hit_q) begin
			moved_sum_q <= moved_sum_q + 38'(mul4_q[50:16]);
		end
		if (state_q == S_RD_WR) begin
			res_q.voxel_density <= signed'(mem_rdata[39:0]);
			res_q.saturated     <= mem_rdata[40];
		end
		if (emit) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`VFDS_ASSERT_IMPLIES(a_read_clears, clk, arst_n, state_q == S_RD_WR, mem_we && (mem_wdata == '0))
	`VFDS_ASSERT_NEVER(a_no_rw_same_cycle, clk, arst_n, mem_we && mem_re)
	`VFDS_ASSERT_IMPLIES(a_corner_write_hits, clk, arst_n, state_q == S_C_WR, hit_q && !clr_busy_q)
	`VFDS_ASSERT_IMPLIES(a_unit_dir_bound, clk, arst_n, norm_done, (norm_res.a_x <= ONE16) && (norm_res.a_y <= ONE16) && (norm_res.a_z <= ONE16))

endmodule

// ===== rtl/vfds_grid_ram.sv =====
module vfds_grid_ram import vfds_pkg::*; #(
	parameter int DEPTH = 32768,
	parameter int AW = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [40:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [40:0]   rdata
);

	logic [40:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/vfds_norm.sv =====
module vfds_norm import vfds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] mag_x,
	input  logic [15:0] mag_y,
	input  logic [15:0] mag_z,
	output logic        done,
	output norm_res_t   res
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_SQ   = 2'd1;
	localparam logic [1:0] P_RT   = 2'd2;
	localparam logic [1:0] P_DV   = 2'd3;

	logic [1:0]  phase_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [15:0] mag_q [3];
	logic [33:0] s_q;
	logic [33:0] s_next;
	logic [31:0] sq;
	logic [35:0] rad_q;
	logic [21:0] rem_q;
	logic [21:0] rem_t;
	logic [21:0] trial;
	logic [17:0] root_q;
	logic [33:0] dvd_q [3];
	logic [17:0] drem_q [3];
	logic [18:0] r_next [3];
	logic        ge [3];
	logic [16:0] a_cl [3];

	// One square per cycle, summed over the three axes.
	assign sq     = 32'(mag_q[cnt_q[1:0]]) * 32'(mag_q[cnt_q[1:0]]);
	assign s_next = s_q + 34'(sq);

	// One root bit per cycle.
	assign rem_t = {rem_q[19:0], rad_q[35:34]};
	assign trial = {2'b00, root_q, 2'b01};

	// Three restoring divider lanes, one quotient bit each per cycle.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		assign r_next[i] = {drem_q[i], dvd_q[i][33]};
		assign ge[i]     = r_next[i] >= {1'b0, root_q};
		assign a_cl[i]   = (dvd_q[i] > 34'(ONE16)) ? ONE16 : dvd_q[i][16:0];
	end

	// Control sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= P_SQ;
						cnt_q   <= '0;
					end
				end
				P_SQ: begin
					cnt_q <= (cnt_q == 6'd2) ? 6'd0 : cnt_q + 6'd1;
					if (cnt_q == 6'd2) begin
						phase_q <= P_RT;
					end
				end
				P_RT: begin
					cnt_q <= (cnt_q == 6'd17) ? 6'd0 : cnt_q + 6'd1;
					if (cnt_q == 6'd17) begin
						phase_q <= P_DV;
					end
				end
				P_DV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd33) begin
						phase_q <= P_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				if (start) begin
					mag_q[0] <= mag_x;
					mag_q[1] <= mag_y;
					mag_q[2] <= mag_z;
					s_q      <= '0;
				end
			end
			P_SQ: begin
				s_q <= s_next;
				if (cnt_q == 6'd2) begin
					rad_q  <= {s_next[31:0], 4'b0000};
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			P_RT: begin
				rad_q <= {rad_q[33:0], 2'b00};
				if (rem_t >= trial) begin
					rem_q  <= rem_t - trial;
					root_q <= {root_q[16:0], 1'b1};
				end else begin
					rem_q  <= rem_t;
					root_q <= {root_q[16:0], 1'b0};
				end
				if (cnt_q == 6'd17) begin
					for (int i = 0; i < 3; i++) begin
						dvd_q[i]  <= {mag_q[i], 18'b0};
						drem_q[i] <= '0;
					end
				end
			end
			P_DV: begin
				for (int i = 0; i < 3; i++) begin
					dvd_q[i]  <= {dvd_q[i][32:0], ge[i]};
					drem_q[i] <= ge[i] ? 18'(r_next[i] - {1'b0, root_q}) : r_next[i][17:0];
				end
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign res.mag_f = root_q;
	assign res.a_x   = a_cl[0];
	assign res.a_y   = a_cl[1];
	assign res.a_z   = a_cl[2];

endmodule
